// ===== design/ncd_pkg.sv =====
// Shared types, constants and control bundles of the negative cycle detector.
`timescale 1ns / 1ps

package ncd_pkg;

    localparam int MaxNodesDefault = 512;
    localparam int MaxEdgesDefault = 8192;

    localparam int NodeW   = 10;
    localparam int CostW   = 14;
    localparam int WeightW = 15;
    localparam int DistW   = 24;

    localparam logic ReqTwoWay = 1'b0;
    localparam logic ReqOneWay = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [NodeW-1:0] src_node;
        logic [NodeW-1:0] dst_node;
        logic [CostW-1:0] travel_time;
        logic             last_edge;
    } edge_req_t;

    typedef struct packed {
        logic has_negative_cycle;
        logic edge_overflow;
    } cycle_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SECOND,
        ST_CLEAR,
        ST_PASS_START,
        ST_FETCH,
        ST_RELAX,
        ST_PASS_END,
        ST_DONE
    } ncd_state_t;

    typedef struct packed {
        logic store_first;
        logic store_second;
        logic clr_init;
        logic clr_step;
        logic pass_init;
        logic pass_step;
        logic idx_init;
        logic idx_step;
        logic fetch;
        logic relax;
        logic res_load;
        logic res_val;
        logic out_load;
    } ncd_cmd_t;

    typedef struct packed {
        logic in_two_way;
        logic in_last;
        logic hold_last;
        logic clr_done;
        logic total_zero;
        logic idx_last;
        logic relax_floor;
        logic pass_last;
        logic changed;
        logic out_free;
    } ncd_status_t;

endpackage

// ===== design/ncd_datapath.sv =====
// Datapath: edge store, distance memory, counters and relaxation arithmetic.
`timescale 1ns / 1ps

module ncd_datapath
    import ncd_pkg::*;
#(
    parameter int MAX_NODES = MaxNodesDefault,
    parameter int MAX_EDGES = MaxEdgesDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ncd_cmd_t         cmd,
    output ncd_status_t      status,
    input  edge_req_t        in_data,
    input  logic             cfg_valid,
    input  logic [NodeW-1:0] cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cycle_result_t    out_data
);

    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int NCNT_W = $clog2(MAX_NODES + 1);
    localparam int DEPTH  = MAX_NODES + 1;

    localparam logic signed [DistW:0] DistFloor = {2'b11, {(DistW - 1){1'b0}}};

    typedef struct packed {
        logic [NodeW-1:0]          from;
        logic [NodeW-1:0]          to;
        logic signed [WeightW-1:0] weight;
    } edge_word_t;

    // storage
    edge_word_t              edge_mem [MAX_EDGES];
    logic signed [DistW-1:0] dist_mem [DEPTH];

    // control registers
    logic [NodeW-1:0]  node_count_reg;
    logic [ECNT_W-1:0] total_reg, total_next;
    logic              ovf_reg, ovf_next;
    logic [ECNT_W-1:0] idx_reg, idx_next;
    logic [NCNT_W-1:0] pass_reg, pass_next;
    logic [NCNT_W-1:0] clr_reg, clr_next;
    logic              changed_reg, changed_next;
    logic              cycle_reg;
    logic              out_valid_reg;

    // payload registers
    edge_req_t               hold_reg;
    edge_word_t              edge_rd_reg;
    logic signed [DistW-1:0] du_reg;
    logic signed [DistW-1:0] dv_reg;
    logic signed [WeightW-1:0] w_reg;
    logic [NodeW-1:0]        v_reg;
    logic                    in_range_reg;
    cycle_result_t           out_reg;

    logic [NCNT_W-1:0]       n_eff;
    logic                    store_en;
    logic                    full;
    edge_word_t              wr_word;
    logic signed [DistW:0]   cand;
    logic                    take;
    logic                    dist_we;
    logic [NCNT_W-1:0]       dist_waddr;
    logic signed [DistW-1:0] dist_wdata;
    logic [WeightW-1:0]      pos_cost;

    // node count clamped into 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NCNT_W'(1);
        end
        else if (32'(node_count_reg) > 32'(MAX_NODES))
        begin
            n_eff = NCNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = NCNT_W'(node_count_reg);
        end
    end

    assign full     = (total_reg == ECNT_W'(MAX_EDGES));
    assign store_en = cmd.store_first || cmd.store_second;

    always_comb
    begin
        if (cmd.store_second)
        begin
            pos_cost       = {1'b0, hold_reg.travel_time};
            wr_word.from   = hold_reg.dst_node;
            wr_word.to     = hold_reg.src_node;
            wr_word.weight = pos_cost;
        end
        else
        begin
            pos_cost       = {1'b0, in_data.travel_time};
            wr_word.from   = in_data.src_node;
            wr_word.to     = in_data.dst_node;
            wr_word.weight = (in_data.req_type == ReqOneWay) ? -pos_cost : pos_cost;
        end
    end

    always_comb
    begin
        total_next = total_reg;
        ovf_next   = ovf_reg;
        if (cmd.out_load)
        begin
            total_next = '0;
            ovf_next   = 1'b0;
        end
        else if (store_en)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                total_next = total_reg + ECNT_W'(1);
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_init)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_step)
        begin
            idx_next = idx_reg + ECNT_W'(1);
        end
    end

    always_comb
    begin
        pass_next = pass_reg;
        if (cmd.pass_init)
        begin
            pass_next = '0;
        end
        else if (cmd.pass_step)
        begin
            pass_next = pass_reg + NCNT_W'(1);
        end
    end

    always_comb
    begin
        clr_next = clr_reg;
        if (cmd.clr_init)
        begin
            clr_next = NCNT_W'(1);
        end
        else if (cmd.clr_step)
        begin
            clr_next = clr_reg + NCNT_W'(1);
        end
    end

    // relaxation of the edge held in the fetch registers
    assign cand = $signed({du_reg[DistW-1], du_reg}) + (DistW + 1)'(w_reg);
    assign take = in_range_reg && (cand < $signed({dv_reg[DistW-1], dv_reg}));

    always_comb
    begin
        changed_next = changed_reg;
        if (cmd.idx_init)
        begin
            changed_next = 1'b0;
        end
        else if (cmd.relax && take && !(cand < DistFloor))
        begin
            changed_next = 1'b1;
        end
    end

    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = clr_reg;
        dist_wdata = '0;
        if (cmd.clr_step)
        begin
            dist_we = 1'b1;
        end
        else if (cmd.relax && take && !(cand < DistFloor))
        begin
            dist_we    = 1'b1;
            dist_waddr = NCNT_W'(v_reg);
            dist_wdata = cand[DistW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NodeW'(1);
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            pass_reg       <= '0;
            clr_reg        <= '0;
            changed_reg    <= 1'b0;
            cycle_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
            pass_reg    <= pass_next;
            clr_reg     <= clr_next;
            changed_reg <= changed_next;
            if (cmd.res_load)
            begin
                cycle_reg <= cmd.res_val;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // edge store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_en && !full)
        begin
            edge_mem[total_reg[EIDX_W-1:0]] <= wr_word;
        end
        edge_rd_reg <= edge_mem[idx_next[EIDX_W-1:0]];
    end

    // distance memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (cmd.fetch)
        begin
            du_reg <= dist_mem[NCNT_W'(edge_rd_reg.from)];
            dv_reg <= dist_mem[NCNT_W'(edge_rd_reg.to)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_first)
        begin
            hold_reg <= in_data;
        end
        if (cmd.fetch)
        begin
            w_reg        <= edge_rd_reg.weight;
            v_reg        <= edge_rd_reg.to;
            in_range_reg <= (edge_rd_reg.from != '0) && (edge_rd_reg.to != '0)
                            && (32'(edge_rd_reg.from) <= 32'(n_eff))
                            && (32'(edge_rd_reg.to) <= 32'(n_eff));
        end
        if (cmd.out_load)
        begin
            out_reg.has_negative_cycle <= cycle_reg;
            out_reg.edge_overflow      <= ovf_reg;
        end
    end

    assign status.in_two_way  = (in_data.req_type == ReqTwoWay);
    assign status.in_last     = in_data.last_edge;
    assign status.hold_last   = hold_reg.last_edge;
    assign status.clr_done    = (clr_reg == n_eff);
    assign status.total_zero  = (total_reg == '0);
    assign status.idx_last    = ((idx_reg + ECNT_W'(1)) == total_reg);
    assign status.relax_floor = take && (cand < DistFloor);
    assign status.pass_last   = ((pass_reg + NCNT_W'(1)) == n_eff);
    assign status.changed     = changed_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/ncd_controller.sv =====
// Controller: sequences edge loading, distance clearing and relaxation passes.
`timescale 1ns / 1ps

module ncd_controller
    import ncd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ncd_status_t status,
    output ncd_cmd_t    cmd
);

    ncd_state_t state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.in_two_way)
                    begin
                        state_next = ST_SECOND;
                    end
                    else if (status.in_last)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_SECOND:
            begin
                state_next = status.hold_last ? ST_CLEAR : ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_PASS_START;
                end
            end
            ST_PASS_START:
            begin
                state_next = status.total_zero ? ST_PASS_END : ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                if (status.relax_floor)
                begin
                    state_next = ST_DONE;
                end
                else if (status.idx_last)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_PASS_END:
            begin
                if (!status.changed || status.pass_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PASS_START;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.store_first = accept;
                cmd.clr_init    = accept && !status.in_two_way && status.in_last;
            end
            ST_SECOND:
            begin
                cmd.store_second = 1'b1;
                cmd.clr_init     = status.hold_last;
            end
            ST_CLEAR:
            begin
                cmd.clr_step  = !status.clr_done;
                cmd.pass_init = status.clr_done;
                // last node is cleared in this cycle as well
                if (status.clr_done)
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_PASS_START:
            begin
                cmd.idx_init = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_RELAX:
            begin
                cmd.relax = 1'b1;
                if (status.relax_floor)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_val  = 1'b1;
                end
                else if (!status.idx_last)
                begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_PASS_END:
            begin
                if (!status.changed)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_val  = 1'b0;
                end
                else if (status.pass_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_val  = 1'b1;
                end
                else
                begin
                    cmd.pass_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/negative_cycle_detector_top.sv =====
// Top level of the negative cycle detector: controller plus datapath.
`timescale 1ns / 1ps
//
// Edge beats arrive on in_valid/in_ready. A one-way beat stores one directed
// edge; a two-way beat stores two, one after the other, through the single
// write port of the edge store. A beat with last_edge set starts the check
// once its edges are stored; in_ready stays low until the answer has been
// placed in the output register. The check clears the n node distances,
// then runs up to n passes over the E stored edges; each edge is fetched
// and then relaxed through the distance memory's read-then-write loop, and
// the check may end early. The answer beat is then loaded into the output
// register and shown on out_valid/out_ready once that register is free.
// If the receiver stalls, the output register holds the beat while the next
// graph loads; a second answer waits until the first has been taken.
// cfg_data sets node_count, always ready; write it only while idle.
// Reset: node_count = 1, the edge store is empty, no answer is pending.
//

module negative_cycle_detector_top
    import ncd_pkg::*;
#(
    parameter int MAX_NODES = MaxNodesDefault,
    parameter int MAX_EDGES = MaxEdgesDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  edge_req_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cycle_result_t    out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [NodeW-1:0] cfg_data
);

    ncd_cmd_t    cmd;
    ncd_status_t status;

    assign cfg_ready = 1'b1;

    ncd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ncd_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
